// ===== rtl/v4n_pkg.sv =====
// Shared widths and types for the four-component vector normaliser.
package v4n_pkg;

   localparam int CompWidth = 16;
   localparam int SumWidth = 33;
   localparam int MagWidth = 17;
   localparam int DivWidth = 31;
   localparam int QuotWidth = 17;
   localparam int UnitOne = 16384;
   localparam int NumComp = 4;

   typedef logic [CompWidth-1:0] abs_type;

   // Per-component state travelling down the divider.
   typedef struct packed {
      logic [DivWidth-1:0] rem;
      logic [QuotWidth-1:0] quot;
      logic neg;
   } div_lane_type;

endpackage

// ===== rtl/vector4_normalize.sv =====
// Top level of the four-component vector normaliser.
// Usage: drive req_comp_* and raise start; a beat is taken at any edge where
// start is high and busy is low. Busy is tied low, so one beat may enter in
// every cycle and the block sustains one vector per clock.
// The first register stage squares the components and sums them; seventeen
// square-root stages then produce the floored length, one bit each; thirty-one
// divider stages form the four quotients in parallel, one bit each. A final
// output register holds the result.
// Each result is shown for exactly one cycle with rsp_valid high; the
// receiver cannot stall, so no back-pressure path exists.
// A zero vector gives zero unit components and a zero magnitude.
// Quotients larger than one, caused by the floored length, saturate at +-1.0.
// Synchronous reset clears every valid bit; payload registers are not reset,
// and results in flight at reset are discarded.
module vector4_normalize (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic signed [15:0] req_comp_x,
   input  logic signed [15:0] req_comp_y,
   input  logic signed [15:0] req_comp_z,
   input  logic signed [15:0] req_comp_w,
   output logic rsp_valid,
   output logic signed [15:0] rsp_unit_x,
   output logic signed [15:0] rsp_unit_y,
   output logic signed [15:0] rsp_unit_z,
   output logic signed [15:0] rsp_unit_w,
   output logic [16:0] rsp_magnitude
);

   localparam int Cw = v4n_pkg::CompWidth;

   logic sq_valid_ff;
   logic [v4n_pkg::SumWidth-1:0] sum_ff;
   logic [v4n_pkg::NumComp*Cw-1:0] comp_ff;
   logic [v4n_pkg::SumWidth-1:0] sum_in;
   logic rt_valid;
   logic [v4n_pkg::MagWidth-1:0] rt_mag;
   logic [v4n_pkg::NumComp*Cw-1:0] rt_comp;
   logic dv_valid;
   logic [v4n_pkg::MagWidth-1:0] dv_mag;
   logic [v4n_pkg::NumComp*Cw-1:0] dv_unit;
   logic out_valid_ff;
   logic [v4n_pkg::MagWidth-1:0] mag_ff;
   logic [v4n_pkg::NumComp*Cw-1:0] unit_ff;

   assign busy = 1'b0;

   // Each square is at most 2^30, so the four-term sum fits 33 bits exactly.
   always_comb begin
      logic signed [2*Cw-1:0] p [v4n_pkg::NumComp];
      p[0] = req_comp_x * req_comp_x;
      p[1] = req_comp_y * req_comp_y;
      p[2] = req_comp_z * req_comp_z;
      p[3] = req_comp_w * req_comp_w;
      sum_in = {1'b0, p[0]} + {1'b0, p[1]} + {1'b0, p[2]} + {1'b0, p[3]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         sq_valid_ff <= start & ~busy;
         out_valid_ff <= dv_valid;
      end
      sum_ff <= sum_in;
      comp_ff <= {req_comp_w, req_comp_z, req_comp_y, req_comp_x};
      mag_ff <= dv_mag;
      unit_ff <= dv_unit;
   end

   v4n_sqrt u_sqrt (
      .clock(clock), .reset(reset), .in_valid(sq_valid_ff), .in_sum(sum_ff),
      .in_comp(comp_ff), .out_valid(rt_valid), .out_mag(rt_mag), .out_comp(rt_comp)
   );

   v4n_div u_div (
      .clock(clock), .reset(reset), .in_valid(rt_valid), .in_mag(rt_mag),
      .in_comp(rt_comp), .out_valid(dv_valid), .out_mag(dv_mag), .out_unit(dv_unit)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_magnitude = mag_ff;
   assign rsp_unit_x = unit_ff[0*Cw +: Cw];
   assign rsp_unit_y = unit_ff[1*Cw +: Cw];
   assign rsp_unit_z = unit_ff[2*Cw +: Cw];
   assign rsp_unit_w = unit_ff[3*Cw +: Cw];

   // The length never exceeds 2^16.
   a_mag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_magnitude <= 17'd65536) else $error("magnitude out of range");
   // A zero length always gives zero x and w unit components.
   a_zero_vec: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_magnitude == '0) |-> (rsp_unit_x == '0 && rsp_unit_w == '0))
      else $error("zero vector gave non-zero unit");
   // The x unit component stays within plus or minus one.
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_unit_x <= 16'sd16384 && rsp_unit_x >= -16'sd16384))
      else $error("unit component out of range");

endmodule

// ===== rtl/v4n_sqrt.sv =====
// Pipelined floored square root of the sum of squares, one result bit per stage.
module v4n_sqrt (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic [v4n_pkg::SumWidth-1:0] in_sum,
   input  logic [v4n_pkg::NumComp*v4n_pkg::CompWidth-1:0] in_comp,
   output logic out_valid,
   output logic [v4n_pkg::MagWidth-1:0] out_mag,
   output logic [v4n_pkg::NumComp*v4n_pkg::CompWidth-1:0] out_comp
);

   localparam int Steps = v4n_pkg::MagWidth;
   localparam int RemWidth = v4n_pkg::MagWidth + 2;
   localparam int PadWidth = 2 * Steps;

   logic [Steps:0] valid_ff;
   logic [PadWidth-1:0] sum_ff [Steps+1];
   logic [RemWidth-1:0] rem_ff [Steps+1];
   logic [v4n_pkg::MagWidth-1:0] root_ff [Steps+1];
   logic [v4n_pkg::NumComp*v4n_pkg::CompWidth-1:0] comp_ff [Steps+1];

   // The sum is widened to an even number of bits so that every stage brings
   // down a full pair.
   always_comb begin
      valid_ff[0] = in_valid;
      sum_ff[0] = PadWidth'(in_sum);
      rem_ff[0] = '0;
      root_ff[0] = '0;
      comp_ff[0] = in_comp;
   end

   // Restoring square root: bring down two bits, try 4*root+1.
   for (genvar s = 0; s < Steps; s++) begin : g_step
      logic [RemWidth-1:0] rem_try;
      logic [RemWidth-1:0] trial;
      logic [RemWidth-1:0] rem_in;
      logic [v4n_pkg::MagWidth-1:0] root_in;
      always_comb begin
         rem_try = {rem_ff[s][RemWidth-3:0],
                    sum_ff[s][2*(Steps-1-s)+1 -: 2]};
         trial = {root_ff[s], 2'b01};
         if (rem_try >= trial) begin
            rem_in = rem_try - trial;
            root_in = {root_ff[s][v4n_pkg::MagWidth-2:0], 1'b1};
         end else begin
            rem_in = rem_try;
            root_in = {root_ff[s][v4n_pkg::MagWidth-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else begin
            valid_ff[s+1] <= valid_ff[s];
         end
         sum_ff[s+1] <= sum_ff[s];
         rem_ff[s+1] <= rem_in;
         root_ff[s+1] <= root_in;
         comp_ff[s+1] <= comp_ff[s];
      end
   end

   assign out_valid = valid_ff[Steps];
   assign out_mag = root_ff[Steps];
   assign out_comp = comp_ff[Steps];

endmodule

// ===== rtl/v4n_div.sv =====
// Pipelined restoring divider for the four components, one quotient bit per stage.
module v4n_div (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic [v4n_pkg::MagWidth-1:0] in_mag,
   input  logic [v4n_pkg::NumComp*v4n_pkg::CompWidth-1:0] in_comp,
   output logic out_valid,
   output logic [v4n_pkg::MagWidth-1:0] out_mag,
   output logic [v4n_pkg::NumComp*v4n_pkg::CompWidth-1:0] out_unit
);

   localparam int Steps = v4n_pkg::DivWidth;
   localparam int Cw = v4n_pkg::CompWidth;
   localparam int Dw = v4n_pkg::DivWidth;
   localparam int Qw = v4n_pkg::QuotWidth;

   logic [Steps:0] valid_ff;
   logic [v4n_pkg::MagWidth-1:0] mag_ff [Steps+1];
   v4n_pkg::div_lane_type lane_ff [Steps+1][v4n_pkg::NumComp];
   logic [Dw-1:0] dvd_ff [Steps+1][v4n_pkg::NumComp];

   always_comb begin
      valid_ff[0] = in_valid;
      mag_ff[0] = in_mag;
      for (int c = 0; c < v4n_pkg::NumComp; c++) begin
         logic signed [Cw-1:0] v;
         logic [Cw-1:0] a;
         v = in_comp[c*Cw +: Cw];
         a = v[Cw-1] ? Cw'(-v) : v;
         lane_ff[0][c].rem = '0;
         lane_ff[0][c].quot = '0;
         lane_ff[0][c].neg = v[Cw-1];
         dvd_ff[0][c] = {1'b0, a, 14'b0};
      end
   end

   // Quotient bits above Qw only saturate, so fold them into a sticky top bit.
   for (genvar s = 0; s < Steps; s++) begin : g_step
      v4n_pkg::div_lane_type lane_in [v4n_pkg::NumComp];
      always_comb begin
         for (int c = 0; c < v4n_pkg::NumComp; c++) begin
            logic [Dw:0] r;
            logic bitq;
            r = {lane_ff[s][c].rem, dvd_ff[s][c][Dw-1-s]};
            bitq = (r >= {{(Dw+1-v4n_pkg::MagWidth){1'b0}}, mag_ff[s]});
            lane_in[c].rem = bitq ? Dw'(r - {{(Dw+1-v4n_pkg::MagWidth){1'b0}}, mag_ff[s]})
                                  : r[Dw-1:0];
            lane_in[c].quot = {lane_ff[s][c].quot[Qw-1] | lane_ff[s][c].quot[Qw-2],
                               lane_ff[s][c].quot[Qw-3:0], bitq};
            lane_in[c].neg = lane_ff[s][c].neg;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else begin
            valid_ff[s+1] <= valid_ff[s];
         end
         mag_ff[s+1] <= mag_ff[s];
         lane_ff[s+1] <= lane_in;
         dvd_ff[s+1] <= dvd_ff[s];
      end
   end

   always_comb begin
      for (int c = 0; c < v4n_pkg::NumComp; c++) begin
         logic [Qw-1:0] q;
         q = lane_ff[Steps][c].quot;
         if (mag_ff[Steps] == '0) q = '0;
         else if (q > Qw'(v4n_pkg::UnitOne)) q = Qw'(v4n_pkg::UnitOne);
         out_unit[c*Cw +: Cw] = lane_ff[Steps][c].neg ? Cw'(-q) : q[Cw-1:0];
      end
   end

   assign out_valid = valid_ff[Steps];
   assign out_mag = mag_ff[Steps];

endmodule
